// ===== design/heightmap_bilinear_sampler_top_defines.svh =====
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_TOP_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_TOP_DEFINES_SVH

// implication checked at the same clock edge, off while reset is high
`define HBS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// implication checked at the following clock edge, off while reset is high
`define HBS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hbs_pkg.sv =====
package hbs_pkg;

  // map size limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // field and register widths
  localparam int DIM_W      = 9;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COORD_W    = 16;
  localparam int PIX_W      = 8;
  localparam int ADDR_W     = 16;
  localparam int OUT_W      = 16;

  // pixel store, split in two banks by address parity
  localparam int BANK_AW    = ADDR_W - 1;
  localparam int BANK_DEPTH = 2 ** BANK_AW;

  // fixed point
  localparam int FRAC_W  = 14;
  localparam int U_W     = FRAC_W + 2;
  localparam int WT_W    = FRAC_W + 1;
  localparam int RB_W    = PIX_W + FRAC_W;
  localparam int V_W     = PIX_W + 2 * FRAC_W;
  localparam int V_SPLIT = V_W / 2;
  localparam int PP_W    = (V_W - V_SPLIT) + SCALE_W;
  localparam int SUM_W   = V_W + SCALE_W;
  localparam int T_W     = PIX_W + SCALE_W;
  localparam int QE_W    = T_W - PIX_W + 1;
  localparam int REM_W   = T_W + 1;

  localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(2 ** FRAC_W);
  localparam logic [U_W-1:0]   U_MAX   = U_W'(2 * (2 ** FRAC_W));
  localparam logic [WT_W-1:0]  ONE_Q   = WT_W'(2 ** FRAC_W);
  localparam int               DIV     = 2 ** PIX_W - 1;
  localparam int               RECIP   = 2 ** PIX_W + 1;
  localparam logic [V_W-1:0]   V_MAX   = V_W'(DIV) << (2 * FRAC_W);

  // register reset values
  localparam logic [DIM_W-1:0]   DIM_RESET   = DIM_W'(256);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH    = 2'd0,
    CFG_MAP_HEIGHT   = 2'd1,
    CFG_HEIGHT_SCALE = 2'd2
  } cfg_idx_t;

  // one bank: one write port, two read ports
  typedef struct packed {
    logic               wr_en;
    logic [BANK_AW-1:0] wr_addr;
    logic [PIX_W-1:0]   wr_data;
    logic [BANK_AW-1:0] rd_addr0;
    logic [BANK_AW-1:0] rd_addr1;
  } bank_req_t;

  // sample bookkeeping that travels beside the bank reads
  typedef struct packed {
    logic              valid;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic              sel00;
    logic              sel01;
    logic              sel10;
    logic              sel11;
  } tap_tag_t;

endpackage

// ===== design/hbs_bank.sv =====
module hbs_bank (
  input  logic                      clk,
  input  hbs_pkg::bank_req_t        req,
  output logic [hbs_pkg::PIX_W-1:0] rd_data0,
  output logic [hbs_pkg::PIX_W-1:0] rd_data1
);
  import hbs_pkg::*;

  logic [PIX_W-1:0] mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data0 <= mem[req.rd_addr0];
    rd_data1 <= mem[req.rd_addr1];
  end

endmodule

// ===== design/hbs_addr.sv =====
`include "heightmap_bilinear_sampler_top_defines.svh"

module hbs_addr (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               operation,
  input  logic [hbs_pkg::ADDR_W-1:0]         pixel_address,
  input  logic [hbs_pkg::PIX_W-1:0]          pixel_red,
  input  logic signed [hbs_pkg::COORD_W-1:0] coord_x,
  input  logic signed [hbs_pkg::COORD_W-1:0] coord_y,
  input  logic [hbs_pkg::DIM_W-1:0]          map_width,
  input  logic [hbs_pkg::DIM_W-1:0]          map_height,
  output hbs_pkg::bank_req_t                 even_req,
  output hbs_pkg::bank_req_t                 odd_req,
  output hbs_pkg::tap_tag_t                  tag
);
  import hbs_pkg::*;

  localparam int PX_W   = COL_W + U_W;
  localparam int PY_W   = ROW_W + U_W;
  localparam int BASE_W = ROW_W + COL_W + 1;

  // saturate to [-1,1] and move to [0,2]
  function automatic logic [U_W-1:0] coord_offset(input logic signed [COORD_W-1:0] c);
    if (c < -COORD_ONE) begin
      coord_offset = '0;
    end else if (c > COORD_ONE) begin
      coord_offset = U_MAX;
    end else begin
      coord_offset = U_W'(c) + U_W'(COORD_ONE);
    end
  endfunction

  function automatic logic [COL_W-1:0] width_m1(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      width_m1 = '0;
    end else if (32'(v) > MAX_WIDTH) begin
      width_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_m1 = COL_W'(v - 1'b1);
    end
  endfunction

  function automatic logic [ROW_W-1:0] height_m1(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      height_m1 = '0;
    end else if (32'(v) > MAX_HEIGHT) begin
      height_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_m1 = ROW_W'(v - 1'b1);
    end
  endfunction

  // stage 1: saturated coordinates
  logic              s1_valid;
  logic              s1_op;
  logic [ADDR_W-1:0] s1_addr;
  logic [PIX_W-1:0]  s1_red;
  logic [U_W-1:0]    s1_ux;
  logic [U_W-1:0]    s1_uy;
  logic [COL_W-1:0]  s1_wm1;
  logic [ROW_W-1:0]  s1_hm1;

  // stage 2: neighbour indices and fractions
  logic              s2_valid;
  logic              s2_op;
  logic [ADDR_W-1:0] s2_addr;
  logic [PIX_W-1:0]  s2_red;
  logic [COL_W-1:0]  s2_c0;
  logic [COL_W-1:0]  s2_c1;
  logic [ROW_W-1:0]  s2_r0;
  logic [ROW_W-1:0]  s2_r1;
  logic [FRAC_W-1:0] s2_fx;
  logic [FRAC_W-1:0] s2_fy;
  logic [COL_W-1:0]  s2_wm1;
  logic [ROW_W-1:0]  s2_hm1;

  logic [PX_W-1:0]   prod_x;
  logic [PY_W-1:0]   prod_y;
  logic [COL_W-1:0]  col0;
  logic [ROW_W-1:0]  row0;
  logic [FRAC_W-1:0] frac_x;
  logic [FRAC_W-1:0] frac_y;

  logic [COL_W:0]    w_full;
  logic [BASE_W-1:0] base0;
  logic [BASE_W-1:0] base1;
  logic [ADDR_W-1:0] a00;
  logic [ADDR_W-1:0] a01;
  logic [ADDR_W-1:0] a10;
  logic [ADDR_W-1:0] a11;
  logic              rd_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_op   <= operation;
    s1_addr <= pixel_address;
    s1_red  <= pixel_red;
    s1_ux   <= coord_offset(coord_x);
    s1_uy   <= coord_offset(coord_y);
    s1_wm1  <= width_m1(map_width);
    s1_hm1  <= height_m1(map_height);
  end

  // position = (size-1)*u/2 with a 14-bit fraction
  assign prod_x = PX_W'(s1_wm1) * PX_W'(s1_ux);
  assign prod_y = PY_W'(s1_hm1) * PY_W'(s1_uy);
  assign col0   = prod_x[COL_W+FRAC_W:FRAC_W+1];
  assign row0   = prod_y[ROW_W+FRAC_W:FRAC_W+1];
  assign frac_x = prod_x[FRAC_W:1];
  assign frac_y = prod_y[FRAC_W:1];

  always_ff @(posedge clk) begin
    s2_op   <= s1_op;
    s2_addr <= s1_addr;
    s2_red  <= s1_red;
    s2_c0   <= col0;
    s2_c1   <= col0 + COL_W'(frac_x != '0);
    s2_r0   <= row0;
    s2_r1   <= row0 + ROW_W'(frac_y != '0);
    s2_fx   <= frac_x;
    s2_fy   <= frac_y;
    s2_wm1  <= s1_wm1;
    s2_hm1  <= s1_hm1;
  end

  // linear addresses row*width+col, wrapping at the store depth
  assign w_full = {1'b0, s2_wm1} + 1'b1;
  assign base0  = BASE_W'(s2_r0) * BASE_W'(w_full);
  assign base1  = BASE_W'(s2_r1) * BASE_W'(w_full);
  assign a00    = ADDR_W'(base0 + BASE_W'(s2_c0));
  assign a01    = ADDR_W'(base0 + BASE_W'(s2_c1));
  assign a10    = ADDR_W'(base1 + BASE_W'(s2_c0));
  assign a11    = ADDR_W'(base1 + BASE_W'(s2_c1));

  assign rd_go = s2_valid && (s2_op == OP_SAMPLE);

  // writes go out at the same stage as reads, so store order equals item order
  always_comb begin
    even_req.wr_en    = s2_valid && (s2_op == OP_WRITE) && !s2_addr[0];
    even_req.wr_addr  = s2_addr[ADDR_W-1:1];
    even_req.wr_data  = s2_red;
    even_req.rd_addr0 = a00[0] ? a01[ADDR_W-1:1] : a00[ADDR_W-1:1];
    even_req.rd_addr1 = a10[0] ? a11[ADDR_W-1:1] : a10[ADDR_W-1:1];

    odd_req.wr_en     = s2_valid && (s2_op == OP_WRITE) && s2_addr[0];
    odd_req.wr_addr   = s2_addr[ADDR_W-1:1];
    odd_req.wr_data   = s2_red;
    odd_req.rd_addr0  = a00[0] ? a00[ADDR_W-1:1] : a01[ADDR_W-1:1];
    odd_req.rd_addr1  = a10[0] ? a10[ADDR_W-1:1] : a11[ADDR_W-1:1];

    tag.valid = rd_go;
    tag.fx    = s2_fx;
    tag.fy    = s2_fy;
    tag.sel00 = a00[0];
    tag.sel01 = a01[0];
    tag.sel10 = a10[0];
    tag.sel11 = a11[0];
  end

  `HBS_ASSERT_IMP(a_tap_in_map, clk, rst, rd_go, (s2_c1 <= s2_wm1) && (s2_r1 <= s2_hm1), "neighbour index beyond map")

endmodule

// ===== design/hbs_blend.sv =====
`include "heightmap_bilinear_sampler_top_defines.svh"

module hbs_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  hbs_pkg::tap_tag_t           tag,
  input  logic [hbs_pkg::PIX_W-1:0]   even_d0,
  input  logic [hbs_pkg::PIX_W-1:0]   even_d1,
  input  logic [hbs_pkg::PIX_W-1:0]   odd_d0,
  input  logic [hbs_pkg::PIX_W-1:0]   odd_d1,
  input  logic [hbs_pkg::SCALE_W-1:0] height_scale,
  output logic                        done,
  output logic [hbs_pkg::OUT_W-1:0]   sample_height
);
  import hbs_pkg::*;

  localparam int SC_W = T_W + PIX_W + 1;

  // stage 3: bank data arrives
  logic              s3_valid;
  logic [FRAC_W-1:0] s3_fx;
  logic [FRAC_W-1:0] s3_fy;
  logic              s3_sel00;
  logic              s3_sel01;
  logic              s3_sel10;
  logic              s3_sel11;
  // stage 4: row blends
  logic              s4_valid;
  logic [RB_W-1:0]   s4_a;
  logic [RB_W-1:0]   s4_b;
  logic [FRAC_W-1:0] s4_fx;
  // stage 5: full blend
  logic              s5_valid;
  logic [V_W-1:0]    s5_v;
  // stage 6: scale partial products
  logic              s6_valid;
  logic [PP_W-1:0]   s6_pp_hi;
  logic [PP_W-1:0]   s6_pp_lo;
  // stage 7: scaled value over 2^28
  logic              s7_valid;
  logic [T_W-1:0]    s7_t;
  // stage 8: quotient estimate
  logic              s8_valid;
  logic [T_W-1:0]    s8_t;
  logic [QE_W-1:0]   s8_q;

  logic [PIX_W-1:0]  p00;
  logic [PIX_W-1:0]  p01;
  logic [PIX_W-1:0]  p10;
  logic [PIX_W-1:0]  p11;
  logic [WT_W-1:0]   wy0;
  logic [WT_W-1:0]   wx0;
  logic [RB_W-1:0]   row_a;
  logic [RB_W-1:0]   row_b;
  logic [V_W-1:0]    v_sum;
  logic [SUM_W-1:0]  prod_full;
  logic [SC_W-1:0]   scaled;
  logic [REM_W-1:0]  rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s3_valid <= tag.valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
      done     <= s8_valid;
    end
  end

  // steer bank ports back to corner taps
  assign p00 = s3_sel00 ? odd_d0 : even_d0;
  assign p01 = s3_sel01 ? odd_d0 : even_d0;
  assign p10 = s3_sel10 ? odd_d1 : even_d1;
  assign p11 = s3_sel11 ? odd_d1 : even_d1;

  assign wy0   = ONE_Q - WT_W'(s3_fy);
  assign row_a = RB_W'(p00) * RB_W'(wy0) + RB_W'(p10) * RB_W'(s3_fy);
  assign row_b = RB_W'(p01) * RB_W'(wy0) + RB_W'(p11) * RB_W'(s3_fy);

  assign wx0   = ONE_Q - WT_W'(s4_fx);
  assign v_sum = V_W'(s4_a) * V_W'(wx0) + V_W'(s4_b) * V_W'(s4_fx);

  assign prod_full = (SUM_W'(s6_pp_hi) << V_SPLIT) + SUM_W'(s6_pp_lo);

  // divide by 255: reciprocal estimate, low by at most one
  assign scaled = SC_W'(s7_t) * SC_W'(RECIP);
  assign rem    = REM_W'(s8_t) + REM_W'(s8_q) - (REM_W'(s8_q) << PIX_W);

  always_ff @(posedge clk) begin
    s3_fx    <= tag.fx;
    s3_fy    <= tag.fy;
    s3_sel00 <= tag.sel00;
    s3_sel01 <= tag.sel01;
    s3_sel10 <= tag.sel10;
    s3_sel11 <= tag.sel11;

    s4_a     <= row_a;
    s4_b     <= row_b;
    s4_fx    <= s3_fx;

    s5_v     <= v_sum;

    s6_pp_hi <= PP_W'(s5_v[V_W-1:V_SPLIT]) * PP_W'(height_scale);
    s6_pp_lo <= PP_W'(s5_v[V_SPLIT-1:0]) * PP_W'(height_scale);

    s7_t     <= prod_full[2*FRAC_W+T_W-1:2*FRAC_W];

    s8_t     <= s7_t;
    s8_q     <= scaled[SC_W-1:2*PIX_W];

    sample_height <= OUT_W'(s8_q + QE_W'(rem >= REM_W'(DIV)));
  end

  `HBS_ASSERT_NXT(a_blend_bound, clk, rst, s4_valid, s5_v <= V_MAX, "blend above full scale")
  `HBS_ASSERT_IMP(a_quot_est, clk, rst, s8_valid, rem < REM_W'(2 * DIV), "quotient estimate off by more than one")

endmodule

// ===== design/heightmap_bilinear_sampler_top.sv =====
// heightmap bilinear sampler
//
// channels: an item is taken at a rising clk edge with start high and busy low.
// operation selects a pixel write (pixel_address, pixel_red) or a sample request
// (coord_x, coord_y, signed Q2.14, saturated to [-1,1]). a sample gives one
// sample_height (unsigned Q8.8) marked by a one-cycle done pulse; a write gives none.
// config: cfg_write with cfg_index 0 map_width, 1 map_height, 2 height_scale;
// other indexes are ignored. write config only while no sample is in flight.
// throughput: one item per clock, any mix of writes and samples. the pixel store
// is two parity banks, each with two read ports, so all four neighbours of a
// sample are fetched in the same cycle.
// order: a sample passes the address stages, the bank read, the blend stages and
// the output register, which sets done and sample_height together; writes land in
// the store in item order with sample reads, so a sample right after a write sees it.
// reset: busy follows rst, the pipeline empties and the registers return to
// 256/256/256; the store is not cleared and reads undefined until written.
// the receiver cannot stall, so nothing ever holds the pipeline.
`include "heightmap_bilinear_sampler_top_defines.svh"

module heightmap_bilinear_sampler_top (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic [hbs_pkg::ADDR_W-1:0]          pixel_address,
  input  logic [hbs_pkg::PIX_W-1:0]           pixel_red,
  input  logic signed [hbs_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [hbs_pkg::COORD_W-1:0]  coord_y,
  // result channel
  output logic                                done,
  output logic [hbs_pkg::OUT_W-1:0]           sample_height,
  // config write port
  input  logic                                cfg_write,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hbs_pkg::*;

  logic [DIM_W-1:0]   map_width;
  logic [DIM_W-1:0]   map_height;
  logic [SCALE_W-1:0] height_scale;

  logic               accept;
  bank_req_t          even_req;
  bank_req_t          odd_req;
  tap_tag_t           tag;
  logic [PIX_W-1:0]   even_d0;
  logic [PIX_W-1:0]   even_d1;
  logic [PIX_W-1:0]   odd_d0;
  logic [PIX_W-1:0]   odd_d1;

  // fully pipelined: only reset holds items off
  assign busy   = rst;
  assign accept = start && !busy;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width    <= DIM_RESET;
      map_height   <= DIM_RESET;
      height_scale <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAP_WIDTH: begin
          map_width <= cfg_data[DIM_W-1:0];
        end
        CFG_MAP_HEIGHT: begin
          map_height <= cfg_data[DIM_W-1:0];
        end
        CFG_HEIGHT_SCALE: begin
          height_scale <= cfg_data[SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // coordinate mapping, neighbour addresses, write issue
  hbs_addr u_addr (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .operation     (operation),
    .pixel_address (pixel_address),
    .pixel_red     (pixel_red),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .map_width     (map_width),
    .map_height    (map_height),
    .even_req      (even_req),
    .odd_req       (odd_req),
    .tag           (tag)
  );

  // even-address bank: port 0 serves the upper row, port 1 the lower row
  hbs_bank u_bank_even (
    .clk      (clk),
    .req      (even_req),
    .rd_data0 (even_d0),
    .rd_data1 (even_d1)
  );

  // odd-address bank
  hbs_bank u_bank_odd (
    .clk      (clk),
    .req      (odd_req),
    .rd_data0 (odd_d0),
    .rd_data1 (odd_d1)
  );

  // interpolation, height scaling and divide by 255
  hbs_blend u_blend (
    .clk           (clk),
    .rst           (rst),
    .tag           (tag),
    .even_d0       (even_d0),
    .even_d1       (even_d1),
    .odd_d0        (odd_d0),
    .odd_d1        (odd_d1),
    .height_scale  (height_scale),
    .done          (done),
    .sample_height (sample_height)
  );

  // every result traces back to an accepted sample request
  `HBS_ASSERT_IMP(a_done_latency, clk, rst, done, $past(accept && (operation == OP_SAMPLE), 9), "result without matching sample")

endmodule
